>>> hw/rtl/lpld_pkg.sv
// Shared types and constants for the length-prefixed list deframer.
`timescale 1ns / 1ps

package lpld_pkg;

  // Magic header bytes "RSList1\n", first byte at index 0
  localparam logic [7:0] MAGIC [8] = '{8'h52, 8'h53, 8'h4C, 8'h69,
                                       8'h73, 8'h74, 8'h31, 8'h0A};

  localparam int unsigned FieldLastPos = 3;
  localparam int unsigned MagicLastPos = 7;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_MAGIC   = 5'b00001,
    PH_COUNT   = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_e;

  // Completion status reported on the final byte
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_ZERO_LEN  = 3'd3,
    ST_TRAILING  = 3'd4
  } status_e;

  // One result item
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        item_first;
    logic        item_last;
    logic [31:0] item_number;
    logic [31:0] item_length;
    logic        done_res;
    status_e     status;
  } res_t;

endpackage

>>> hw/rtl/lpld_parser.sv
// Parse state registers and the per-byte step logic of the deframer.
`timescale 1ns / 1ps

module lpld_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output lpld_pkg::res_t res_o
);
  import lpld_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] items_q, items_d;
  logic [31:0] left_q, left_d;
  logic [31:0] item_q, item_d;
  logic [31:0] len_q, len_d;
  status_e     err_q, err_d;
  logic [31:0] shift_w;

  assign shift_w = {shift_q[23:0], byte_i};

  // Advance the parse state by one byte and form its result
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    shift_d = shift_q;
    items_d = items_q;
    left_d  = left_q;
    item_d  = item_q;
    len_d   = len_q;
    err_d   = err_q;
    res_o   = '0;

    if (err_q == ST_OK) begin
      unique case (phase_q)
        PH_MAGIC: begin
          if (byte_i != MAGIC[pos_q]) begin
            err_d = ST_BAD_MAGIC;
          end else if (pos_q == 3'(MagicLastPos)) begin
            phase_d = PH_COUNT;
            pos_d   = '0;
            shift_d = '0;
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end
        PH_COUNT, PH_LEN: begin
          shift_d = shift_w;
          if (pos_q >= 3'(FieldLastPos)) begin
            pos_d   = '0;
            shift_d = '0;
            if (phase_q == PH_COUNT) begin
              items_d = shift_w;
              item_d  = '0;
              phase_d = (shift_w == '0) ? PH_DONE : PH_LEN;
            end else if (shift_w == '0) begin
              err_d = ST_ZERO_LEN;
            end else begin
              len_d   = shift_w;
              left_d  = shift_w;
              phase_d = PH_PAYLOAD;
            end
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          res_o.data_byte   = byte_i;
          res_o.data_valid  = 1'b1;
          res_o.item_first  = (left_q == len_q);
          res_o.item_last   = (left_q == 32'd1);
          res_o.item_number = item_q;
          res_o.item_length = len_q;
          left_d = left_q - 32'd1;
          if (left_q == 32'd1) begin
            item_d  = item_q + 32'd1;
            items_d = items_q - 32'd1;
            phase_d = (items_q == 32'd1) ? PH_DONE : PH_LEN;
          end
        end
        PH_DONE: begin
          err_d = ST_TRAILING;
        end
        default: begin
          phase_d = PH_MAGIC;
          pos_d   = '0;
        end
      endcase
    end

    // Report status on the final byte and drop back to reset state
    if (last_i) begin
      res_o.done_res = 1'b1;
      if (err_d != ST_OK) begin
        res_o.status = err_d;
      end else if (phase_d == PH_DONE) begin
        res_o.status = ST_OK;
      end else begin
        res_o.status = ST_TRUNCATED;
      end
      phase_d = PH_MAGIC;
      pos_d   = '0;
      shift_d = '0;
      items_d = '0;
      left_d  = '0;
      item_d  = '0;
      len_d   = '0;
      err_d   = ST_OK;
    end
  end

  // Hold state unless a byte is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      pos_q   <= '0;
      shift_q <= '0;
      items_q <= '0;
      left_q  <= '0;
      item_q  <= '0;
      len_q   <= '0;
      err_q   <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      items_q <= items_d;
      left_q  <= left_d;
      item_q  <= item_d;
      len_q   <= len_d;
      err_q   <= err_d;
    end
  end

endmodule

>>> hw/rtl/length_prefixed_list_deframer.sv
// Top level of the length-prefixed list deframer: input and result stages.
// Flow: an accepted byte is held in the input stage, and its parsed result is
// then loaded into the result register, which drives the output.
// Throughput: one byte per cycle unless the output stalls; the input stage and
// result register form a two-stage pipeline, each advancing when the next frees.
// Reset: asynchronous active low; parser returns to the magic phase, both
// stages empty. Parser state also returns to reset after each final byte.
`timescale 1ns / 1ps

module length_prefixed_list_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] data_byte, [39:8] item_number,
                                      // [71:40] item_length
  output logic [7:0]  m_axis_tuser,   // [0] data_valid, [1] item_first,
                                      // [2] item_last, [5:3] status, [7:6] zero
  output logic        m_axis_tlast    // done_res
);
  import lpld_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q;
  res_t       res_q;
  res_t       res_w;
  logic       out_adv;
  logic       step;

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_adv;
  assign step          = in_vld_q && out_adv;

  lpld_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res_w)
  );

  // Input stage: take a request whenever the stage frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Result register: load the parsed result, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_w;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {res_q.item_length, res_q.item_number, res_q.data_byte};
  assign m_axis_tuser  = {2'b00, res_q.status, res_q.item_last, res_q.item_first,
                          res_q.data_valid};
  assign m_axis_tlast  = res_q.done_res;

endmodule

>>> hw/rtl/lpld_checker.sv
// Port-level assertions for the deframer, bound to the top level.
`timescale 1ns / 1ps

module lpld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Non-payload results carry zero payload fields and no item marks
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata == 72'd0 && m_axis_tuser[2:1] == 2'b00)
    else $error("payload fields set on a non-payload result");

  // Status is only reported on the final-byte result
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[5:3] == 3'd0)
    else $error("status set without done");

  // Status code stays in its defined range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[5:3] <= 3'd4 && m_axis_tuser[7:6] == 2'b00)
    else $error("status code out of range");

  // A stalled result request holds its contents
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // With no result waiting the input side is always ready
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result side");

endmodule

bind length_prefixed_list_deframer lpld_checker u_lpld_checker (.*);
